// ===== hdl/lpoq_pkg.sv =====
// Shared types and constants for the lossless pause output queue.
package lpoq_pkg;

  localparam logic [1:0] CMD_PAUSE   = 2'd0;
  localparam logic [1:0] CMD_ARRIVE  = 2'd1;
  localparam logic [1:0] CMD_TX_DONE = 2'd2;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_DEPART = 1'b1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_THRESHOLD = 2'd1;

  // telemetry is written only below this hop index
  localparam logic [3:0] MAX_HOPS = 4'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pause_time;
    logic [13:0] pkt_size;
    logic [5:0]  ingress_port;
    logic        ce_in;
    logic        is_hpcc;
    logic [2:0]  int_hop;
    logic [47:0] now;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [13:0] out_size;
    logic [5:0]  out_port;
    logic        ecn_ce;
    logic        int_valid;
    logic [2:0]  int_slot;
    logic [23:0] int_queue_bytes;
    logic [47:0] int_time;
    logic [47:0] int_tx_bytes;
    logic        overflow_seen;
  } result_t;

  typedef struct packed {
    logic [2:0]  hop;
    logic        hpcc;
    logic        ce;
    logic [5:0]  port;
    logic [13:0] size;
  } desc_t;

endpackage

// ===== hdl/lpoq_desc_mem.sv =====
// Descriptor storage: one write port, one registered read port.
module lpoq_desc_mem
  import lpoq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  desc_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output desc_t         rd_data
);

  desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lpoq_out_stage.sv =====
// Output register for result transactions.
module lpoq_out_stage
  import lpoq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  output logic    valid,
  input  logic    stall,
  output result_t data
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ===== hdl/lossless_pause_output_queue.sv =====
// Output queue for lossless Ethernet: pause handling, descriptor FIFO, ECN and telemetry.
// Per input transaction: a pause frame, a dropped or non-starting arrival, or an ignored
// transmit-done is finished in idle; an arrival that starts the head builds the start
// from the arriving fields; a resume that starts the head first reads the head descriptor;
// a transmit-done reads it for the departure and then reads the next head when that one
// starts too. Reads go through the memory's registered read port, each result is handed
// to the output register, and a stall on the output side holds the hand-off. The descriptor
// memory needs no clearing after reset; only entries that were written are ever read.
module lossless_pause_output_queue
  import lpoq_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START_RD,
    S_DEPART_RD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEND_READY,
    SEND_PAUSE_RCVD,
    SEND_PAUSED
  } send_t;

  state_t        state;
  send_t         send_st;
  send_t         send_after;
  logic [PW-1:0] head_ptr;
  logic [PW-1:0] tail_ptr;
  logic [PW-1:0] head_ptr_next;
  logic [PW-1:0] tail_ptr_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_after;
  logic [23:0]   queued_bytes;
  logic [47:0]   sent_bytes;
  logic          busy;
  logic          overflow;
  logic          ecn_en;
  logic [23:0]   ecn_thr;
  logic [47:0]   now_q;
  result_t       pend;
  logic          follow;

  logic          item_acc;
  logic          full;
  logic          mem_wr_en;
  logic          mem_rd_en;
  logic [PW-1:0] mem_rd_addr;
  desc_t         mem_wr_data;
  desc_t         mem_rd_data;
  logic          out_free;
  logic          out_load;
  logic [24:0]   qb_sum;
  logic [23:0]   qb_add;
  logic [23:0]   qb_sub;
  logic          follow_next;
  result_t       depart_res;

  function automatic result_t start_result(desc_t d, logic ovf);
    result_t r;
    r               = '0;
    r.kind          = KIND_START;
    r.last          = 1'b1;
    r.out_size      = d.size;
    r.out_port      = d.port;
    r.overflow_seen = ovf;
    return r;
  endfunction

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign full       = (count == CW'(FIFO_DEPTH));

  assign head_ptr_next = (head_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_ptr_next = (tail_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;

  assign mem_wr_data.hop  = item.int_hop;
  assign mem_wr_data.hpcc = item.is_hpcc;
  assign mem_wr_data.ce   = item.ce_in;
  assign mem_wr_data.port = item.ingress_port;
  assign mem_wr_data.size = item.pkt_size;

  // writes happen only at acceptance in idle, reads only for pause/tx-done or
  // in the departure cycle, so the same entry is never written and read at once
  assign mem_wr_en = item_acc && (item.cmd == CMD_ARRIVE) && !full;

  assign count_after = count - 1'b1;
  assign send_after  = (send_st == SEND_PAUSE_RCVD) ? SEND_PAUSED : send_st;
  assign follow_next = (count_after != '0) && (send_after == SEND_READY);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_ptr;
    if (state == S_DEPART_RD) begin
      mem_rd_en   = follow_next;
      mem_rd_addr = head_ptr_next;
    end else if (item_acc) begin
      case (item.cmd)
        CMD_PAUSE:   mem_rd_en = (item.pause_time == '0) && (count != '0) && !busy;
        CMD_TX_DONE: mem_rd_en = busy && (count != '0);
        default:     mem_rd_en = 1'b0;
      endcase
    end
  end

  assign qb_sum = {1'b0, queued_bytes} + {11'b0, item.pkt_size};
  assign qb_add = qb_sum[24] ? 24'hFFFFFF : qb_sum[23:0];
  assign qb_sub = (queued_bytes > {10'b0, mem_rd_data.size})
                  ? queued_bytes - {10'b0, mem_rd_data.size} : '0;

  always_comb begin
    depart_res               = '0;
    depart_res.kind          = KIND_DEPART;
    depart_res.last          = !follow_next;
    depart_res.out_size      = mem_rd_data.size;
    depart_res.out_port      = mem_rd_data.port;
    depart_res.ecn_ce        = mem_rd_data.ce || (ecn_en && (queued_bytes > ecn_thr));
    depart_res.overflow_seen = overflow;
    if (mem_rd_data.hpcc && ({1'b0, mem_rd_data.hop} < MAX_HOPS)) begin
      depart_res.int_valid       = 1'b1;
      depart_res.int_slot        = mem_rd_data.hop;
      depart_res.int_queue_bytes = queued_bytes;
      depart_res.int_time        = now_q;
      depart_res.int_tx_bytes    = sent_bytes;
    end
  end

  assign out_load = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      send_st      <= SEND_READY;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      count        <= '0;
      queued_bytes <= '0;
      sent_bytes   <= '0;
      busy         <= 1'b0;
      overflow     <= 1'b0;
      ecn_en       <= 1'b0;
      ecn_thr      <= '0;
      follow       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ECN_ENABLE:    ecn_en  <= cfg_data[0];
          REG_ECN_THRESHOLD: ecn_thr <= cfg_data;
          default:           ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            now_q <= item.now;
            case (item.cmd)
              CMD_PAUSE: begin
                if (item.pause_time != '0) begin
                  send_st <= busy ? SEND_PAUSE_RCVD : SEND_PAUSED;
                end else begin
                  send_st <= SEND_READY;
                  if ((count != '0) && !busy) begin
                    busy  <= 1'b1;
                    state <= S_START_RD;
                  end
                end
              end
              CMD_ARRIVE: begin
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  tail_ptr     <= tail_ptr_next;
                  count        <= count + 1'b1;
                  queued_bytes <= qb_add;
                  // empty queue and not paused: the new entry is the head, start it from the item itself
                  if ((count == '0) && (send_st == SEND_READY) && !busy) begin
                    busy   <= 1'b1;
                    pend   <= start_result(mem_wr_data, overflow);
                    follow <= 1'b0;
                    state  <= S_EMIT;
                  end
                end
              end
              CMD_TX_DONE: begin
                if (busy && (count != '0)) begin
                  state <= S_DEPART_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_START_RD: begin
          pend   <= start_result(mem_rd_data, overflow);
          follow <= 1'b0;
          state  <= S_EMIT;
        end
        S_DEPART_RD: begin
          pend         <= depart_res;
          head_ptr     <= head_ptr_next;
          count        <= count_after;
          queued_bytes <= qb_sub;
          sent_bytes   <= sent_bytes + {34'b0, mem_rd_data.size};
          send_st      <= send_after;
          busy         <= follow_next;
          follow       <= follow_next;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= follow ? S_START_RD : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lpoq_desc_mem #(
    .DEPTH (FIFO_DEPTH),
    .AW    (PW)
  ) u_desc_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_ptr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lpoq_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (pend),
    .free      (out_free),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (result)
  );

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("entry count above depth");

  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("sending with empty queue");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    ((count == '0) || (count == CW'(FIFO_DEPTH))) |-> (head_ptr == tail_ptr))
    else $error("pointers disagree with entry count");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_wr_en && mem_rd_en))
    else $error("descriptor read and write in one cycle");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result_valid)
    else $error("result transaction lost at output register");
`endif

endmodule

// ===== test/lossless_pause_output_queue_test.sv =====
// Self-checking testbench for the lossless pause output queue.
`timescale 1ns / 100ps

module lossless_pause_output_queue_test;
  import lpoq_pkg::*;

  localparam int QDEPTH = 1024;
  localparam int SETTLE = 8;          // covers the longest per-transaction latency
  localparam int WATCHDOG = 2000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {TX_READY, TX_PAUSE_PENDING, TX_PAUSED} tx_gate_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model of the port
  desc_t desc_mem [QDEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned n_queued = 0;
  logic [23:0] backlog = '0;
  logic [47:0] tx_total = '0;
  tx_gate_t gate = TX_READY;
  bit sending = 1'b0;
  bit overflowed = 1'b0;
  bit mark_on = 1'b0;
  logic [23:0] mark_thresh = '0;

  result_t tx_events_new [2];
  result_t tx_events_due [$];
  result_t due_event;
  script_row_t script [$];
  int fails = 0;
  int sink_pct = 0;
  int quiet_cycles = 0;

  lossless_pause_output_queue #(.FIFO_DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t head_start();
    result_t r;
    desc_t d;
    d = desc_mem[rd_ptr];
    sending = 1'b1;
    r = '0;
    r.kind = KIND_START;
    r.out_size = d.size;
    r.out_port = d.port;
    r.overflow_seen = overflowed;
    return r;
  endfunction

  // Advances the model by one input transaction; results land in tx_events_new.
  function automatic int project_tx_events(item_t it);
    result_t r;
    desc_t d;
    logic [24:0] sum;
    bit was_empty;
    int n;
    n = 0;
    case (it.cmd)
      CMD_PAUSE: begin
        if (it.pause_time != 0) begin
          gate = sending ? TX_PAUSE_PENDING : TX_PAUSED;
        end else begin
          gate = TX_READY;
          if (n_queued > 0 && !sending) begin
            tx_events_new[0] = head_start();
            n = 1;
          end
        end
      end
      CMD_ARRIVE: begin
        if (n_queued >= QDEPTH) begin
          overflowed = 1'b1;
        end else begin
          was_empty = (n_queued == 0);
          d.size = it.pkt_size;
          d.port = it.ingress_port;
          d.ce = it.ce_in;
          d.hpcc = it.is_hpcc;
          d.hop = it.int_hop;
          desc_mem[wr_ptr] = d;
          wr_ptr = (wr_ptr + 1) % QDEPTH;
          n_queued++;
          sum = {1'b0, backlog} + 25'(it.pkt_size);
          backlog = sum[24] ? 24'hFF_FFFF : sum[23:0];
          if (was_empty && gate == TX_READY && !sending) begin
            tx_events_new[0] = head_start();
            n = 1;
          end
        end
      end
      CMD_TX_DONE: begin
        if (sending && n_queued > 0) begin
          d = desc_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDEPTH;
          n_queued--;
          r = '0;
          r.kind = KIND_DEPART;
          r.out_size = d.size;
          r.out_port = d.port;
          r.ecn_ce = d.ce | (mark_on & (backlog > mark_thresh));
          // telemetry snapshot is taken before the counters move
          if (d.hpcc && {1'b0, d.hop} < MAX_HOPS) begin
            r.int_valid = 1'b1;
            r.int_slot = d.hop;
            r.int_queue_bytes = backlog;
            r.int_time = it.now;
            r.int_tx_bytes = tx_total;
          end
          backlog = (backlog > 24'(d.size)) ? backlog - 24'(d.size) : '0;
          tx_total = tx_total + 48'(d.size);
          sending = 1'b0;
          if (gate == TX_PAUSE_PENDING) gate = TX_PAUSED;
          r.overflow_seen = overflowed;
          tx_events_new[0] = r;
          n = 1;
          if (n_queued > 0 && gate == TX_READY) begin
            tx_events_new[1] = head_start();
            n = 2;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) tx_events_new[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic item_t port_event(logic [1:0] cmd, logic [15:0] pt, logic [13:0] sz,
                                       logic [5:0] port, logic ce, logic hpcc,
                                       logic [2:0] hop, logic [47:0] now);
    item_t it;
    it.cmd = cmd;
    it.pause_time = pt;
    it.pkt_size = sz;
    it.ingress_port = port;
    it.ce_in = ce;
    it.is_hpcc = hpcc;
    it.int_hop = hop;
    it.now = now;
    return it;
  endfunction

  // Single-result expectation for the hand-written rows (no overflow yet).
  function automatic result_t typed_result(logic kind, logic [13:0] sz, logic [5:0] port,
                                           logic ce, logic iv, logic [2:0] slot,
                                           logic [23:0] qb, logic [47:0] tm,
                                           logic [47:0] tx);
    result_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    r.out_size = sz;
    r.out_port = port;
    r.ecn_ce = ce;
    r.int_valid = iv;
    r.int_slot = slot;
    r.int_queue_bytes = qb;
    r.int_time = tm;
    r.int_tx_bytes = tx;
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [63:0] w;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 44) it.cmd = CMD_ARRIVE;
    else if (p < 82) it.cmd = CMD_TX_DONE;
    else if (p < 97) it.cmd = CMD_PAUSE;
    else it.cmd = CMD_UNUSED;
    it.pause_time = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
    p = $urandom_range(0, 9);
    if (p == 0) it.pkt_size = '0;
    else if (p == 1) it.pkt_size = 14'h3FFF;
    else it.pkt_size = 14'($urandom_range(0, 14'h3FFF));
    it.ingress_port = 6'($urandom_range(0, 63));
    it.ce_in = 1'($urandom_range(0, 1));
    it.is_hpcc = ($urandom_range(0, 3) != 0);
    it.int_hop = 3'($urandom_range(0, 7));
    w = {$urandom(), $urandom()};
    it.now = w[47:0];
    return it;
  endfunction

  function automatic void match_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic add_row(item_t it, bit typed, result_t want);
    script_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  task automatic send(item_t it, bit typed, result_t want);
    int n;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    n = project_tx_events(it);
    if (typed) begin
      tx_events_due.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) tx_events_due.push_back(tx_events_new[i]);
    end
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (tx_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(bit en, logic [CFG_DATA_W-1:0] thr);
    cfg_index <= REG_ECN_ENABLE;
    cfg_data <= CFG_DATA_W'(en);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mark_on = en;
    cfg_index <= REG_ECN_THRESHOLD;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    mark_thresh = thr;
    cfg_valid <= 1'b0;
  endtask

  // Resume and send transmit-done until the queue is empty.
  task automatic drain(int gap_pct);
    item_t it;
    if (n_queued == 0) return;
    it = random_item();
    it.cmd = CMD_PAUSE;
    it.pause_time = '0;
    sender_gap(gap_pct);
    send(it, 1'b0, '0);
    while (n_queued > 0) begin
      it = random_item();
      it.cmd = CMD_TX_DONE;
      sender_gap(gap_pct);
      send(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(bit en, logic [CFG_DATA_W-1:0] thr, int n, int gap_pct,
                           int stall_pct);
    wait_idle();
    write_cfg(en, thr);
    sink_pct = stall_pct;
    repeat (n) begin
      sender_gap(gap_pct);
      send(random_item(), 1'b0, '0);
    end
    drain(gap_pct);
  endtask

  // Output side: random stall bursts.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < sink_pct) begin
        hold = $urandom_range(1, 8);
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (tx_events_due.size() == 0) begin
        $error("unexpected result: kind %0d size %0d port %0d",
               result.kind, result.out_size, result.out_port);
        fails++;
      end else begin
        due_event = tx_events_due.pop_front();
        match_field("kind", due_event.kind, result.kind);
        match_field("last", due_event.last, result.last);
        match_field("out_size", due_event.out_size, result.out_size);
        match_field("out_port", due_event.out_port, result.out_port);
        match_field("ecn_ce", due_event.ecn_ce, result.ecn_ce);
        match_field("int_valid", due_event.int_valid, result.int_valid);
        match_field("int_slot", due_event.int_slot, result.int_slot);
        match_field("int_queue_bytes", due_event.int_queue_bytes, result.int_queue_bytes);
        match_field("int_time", due_event.int_time, result.int_time);
        match_field("int_tx_bytes", due_event.int_tx_bytes, result.int_tx_bytes);
        match_field("overflow_seen", due_event.overflow_seen, result.overflow_seen);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    // directed rows, run with the registers at their reset values
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_UNUSED, 16'hFFFF, 14'h3FFF, 6'd63, 1'b1, 1'b1, 3'd7,
                       48'hFFFF_FFFF_FFFF), 1'b0, '0);
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'h3FFF, 6'd63, 1'b0, 1'b1, 3'd0,
                       48'hFFFF_FFFF_FFFF),
            1'b1, typed_result(KIND_START, 14'h3FFF, 6'd63, 1'b0, 1'b0, 3'd0, 24'd0,
                               48'd0, 48'd0));
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'h0, 6'd0, 1'b1, 1'b1, 3'd4, 48'h0), 1'b0, '0);
    // pause lands mid-transmission
    add_row(port_event(CMD_PAUSE, 16'hFFFF, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0,
                       48'hFFFF_FFFF_FFFF),
            1'b1, typed_result(KIND_DEPART, 14'h3FFF, 6'd63, 1'b0, 1'b1, 3'd0, 24'd16383,
                               48'hFFFF_FFFF_FFFF, 48'd0));
    add_row(port_event(CMD_PAUSE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0),
            1'b1, typed_result(KIND_START, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 24'd0,
                               48'd0, 48'd0));
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0),
            1'b1, typed_result(KIND_DEPART, 14'h0, 6'd0, 1'b1, 1'b1, 3'd4, 24'd0,
                               48'd0, 48'd16383));
    add_row(port_event(CMD_PAUSE, 16'h1, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_PAUSE, 16'h1, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    // arrivals while paused: no start; hops at and above the telemetry limit
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'd100, 6'd5, 1'b0, 1'b1, 3'd5, 48'h1), 1'b0, '0);
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'd200, 6'd42, 1'b0, 1'b1, 3'd7, 48'h2), 1'b0, '0);
    add_row(port_event(CMD_PAUSE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0),
            1'b1, typed_result(KIND_START, 14'd100, 6'd5, 1'b0, 1'b0, 3'd0, 24'd0,
                               48'd0, 48'd0));
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h1234),
            1'b0, '0);
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'd1, 6'd21, 1'b1, 1'b0, 3'd3, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h5678),
            1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h9ABC),
            1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'h2AAA, 6'd42, 1'b0, 1'b1, 3'd2,
                       48'hAAAA_AAAA_AAAA), 1'b0, '0);
    add_row(port_event(CMD_PAUSE, 16'h5555, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    // resume while still sending: no new start
    add_row(port_event(CMD_PAUSE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0, 48'h0), 1'b0, '0);
    add_row(port_event(CMD_ARRIVE, 16'h0, 14'h1555, 6'd21, 1'b1, 1'b1, 3'd1,
                       48'h5555_5555_5555), 1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0,
                       48'h5555_5555_5555), 1'b0, '0);
    add_row(port_event(CMD_TX_DONE, 16'h0, 14'h0, 6'd0, 1'b0, 1'b0, 3'd0,
                       48'hAAAA_AAAA_AAAA), 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sink_pct = 20;
    foreach (script[i]) begin
      sender_gap(20);
      send(script[i].it, script[i].typed, script[i].want);
    end
    drain(20);

    run_phase(1'b1, 24'd0, 60, 25, 25);
    run_phase(1'b1, 24'hFF_FFFF, 60, 0, 40);
    run_phase(1'b1, 24'($urandom_range(0, 40000)), 60, 30, 0);
    run_phase(1'b0, 24'($urandom_range(0, 24'hFF_FFFF)), 60, 25, 25);

    // closing stretch with no idling on either side: fill the queue while paused
    // until arrivals are dropped, then resume and let part of it depart
    wait_idle();
    write_cfg(1'b1, 24'd8_000_000);
    sink_pct = 0;
    it = random_item();
    it.cmd = CMD_PAUSE;
    it.pause_time = 16'h8000;
    send(it, 1'b0, '0);
    repeat (QDEPTH + 6) begin
      it = random_item();
      it.cmd = CMD_ARRIVE;
      it.pkt_size = 14'($urandom_range(12000, 14'h3FFF));
      send(it, 1'b0, '0);
    end
    it = random_item();
    it.cmd = CMD_PAUSE;
    it.pause_time = '0;
    send(it, 1'b0, '0);
    repeat (40) begin
      it = random_item();
      it.cmd = CMD_TX_DONE;
      send(it, 1'b0, '0);
    end

    wait_idle();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
